[hdl/pfc_pkg.sv]
// shared types, codes and register indexes of the pixel format converter
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_LAYOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_LAYOUT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_PREMUL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_PREMUL = 2'd3;

   localparam logic [2:0] LAYOUT_BGRA = 3'd0;
   localparam logic [2:0] LAYOUT_ARGB = 3'd1;
   localparam logic [2:0] LAYOUT_RGBA = 3'd2;
   localparam logic [2:0] LAYOUT_ABGR = 3'd3;
   localparam logic [2:0] LAYOUT_BGR  = 3'd4;
   localparam logic [2:0] LAYOUT_RGB  = 3'd5;

   localparam logic [1:0] DST_BGRA_LIKE = 2'd0;
   localparam logic [1:0] DST_RGBA_LIKE = 2'd1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [15:0] ROUND_HALF  = 16'h0080;

   // number of divider stages, two quotient bits each
   localparam int DIV_STAGES = 4;

   typedef enum logic [1:0] {
      MODE_COPY,
      MODE_PREMUL,
      MODE_UNPREMUL
   } pfc_mode_type;

   typedef struct packed {
      logic [7:0] in_byte0;
      logic [7:0] in_byte1;
      logic [7:0] in_byte2;
      logic [7:0] in_byte3;
      logic       last_pixel;
   } pfc_req_type;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic       out_last;
   } pfc_rsp_type;

   typedef struct packed {
      logic [2:0] src_layout;
      logic [1:0] dst_layout;
      logic       src_premultiplied;
      logic       dst_premultiplied;
   } pfc_cfg_type;

   // reordered pixel, byte 3 is alpha
   typedef struct packed {
      logic            valid;
      logic            last;
      pfc_mode_type    mode;
      logic [3:0][7:0] pix;
   } pfc_sw_type;

endpackage

`default_nettype wire

[hdl/pfc_swizzle.sv]
// byte reordering stage: picks the permutation and the alpha operation
`timescale 1ns / 1ps
`default_nettype none

module pfc_swizzle (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire pfc_pkg::pfc_req_type req,
   input  wire pfc_pkg::pfc_cfg_type cfg,
   output pfc_pkg::pfc_sw_type       sw
);
   import pfc_pkg::*;

   typedef enum logic [1:0] {
      PERM_IDENT,
      PERM_REVERSE,
      PERM_SWAP,
      PERM_ROTATE
   } pfc_perm_type;

   pfc_perm_type    perm;
   logic            flip;
   logic            packed_src;
   logic [3:0][7:0] s;
   logic [3:0][7:0] d;
   pfc_sw_type      sw_ff;
   pfc_sw_type      sw_in;

   assign s[0] = req.in_byte0;
   assign s[1] = req.in_byte1;
   assign s[2] = req.in_byte2;
   assign s[3] = req.in_byte3;
   assign packed_src = (cfg.src_layout == LAYOUT_BGR) || (cfg.src_layout == LAYOUT_RGB);

   always_comb begin
      perm = PERM_IDENT;
      flip = 1'b0;
      unique case (cfg.dst_layout)
         DST_BGRA_LIKE: begin
            unique case (cfg.src_layout)
               LAYOUT_ARGB: perm = PERM_REVERSE;
               LAYOUT_RGBA: perm = PERM_SWAP;
               LAYOUT_ABGR: perm = PERM_ROTATE;
               LAYOUT_RGB:  flip = 1'b1;
               default:     perm = PERM_IDENT;
            endcase
         end
         DST_RGBA_LIKE: begin
            unique case (cfg.src_layout)
               LAYOUT_ABGR: perm = PERM_REVERSE;
               LAYOUT_BGRA: perm = PERM_SWAP;
               LAYOUT_ARGB: perm = PERM_ROTATE;
               LAYOUT_BGR:  flip = 1'b1;
               default:     perm = PERM_IDENT;
            endcase
         end
         default: begin
            perm = PERM_IDENT;
         end
      endcase
   end

   always_comb begin
      if (packed_src) begin
         d[0] = flip ? s[2] : s[0];
         d[1] = s[1];
         d[2] = flip ? s[0] : s[2];
         d[3] = ALPHA_OPAQUE;
      end else begin
         unique case (perm)
            PERM_REVERSE: d = {s[0], s[1], s[2], s[3]};
            PERM_SWAP:    d = {s[3], s[0], s[1], s[2]};
            PERM_ROTATE:  d = {s[0], s[3], s[2], s[1]};
            default:      d = s;
         endcase
      end
   end

   always_comb begin
      sw_in.valid = accept;
      sw_in.last  = req.last_pixel;
      sw_in.pix   = d;
      sw_in.mode  = MODE_COPY;
      if (!packed_src && (cfg.src_premultiplied != cfg.dst_premultiplied)) begin
         priority if (d[3] == ALPHA_CLEAR) begin
            sw_in.pix = '0;
         end else if (d[3] != ALPHA_OPAQUE) begin
            sw_in.mode = cfg.src_premultiplied ? MODE_UNPREMUL : MODE_PREMUL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff.valid <= 1'b0;
      end else begin
         sw_ff.valid <= sw_in.valid;
      end
      sw_ff.last <= sw_in.last;
      sw_ff.mode <= sw_in.mode;
      sw_ff.pix  <= sw_in.pix;
   end

   assign sw = sw_ff;

   pfc_packed_opaque_a: assert property (@(posedge clock) disable iff (reset)
      (accept && packed_src) |=> (sw_ff.pix[3] == ALPHA_OPAQUE && sw_ff.mode == MODE_COPY))
      else $error("packed source lost its opaque alpha");

endmodule

`default_nettype wire

[hdl/pfc_alpha.sv]
// alpha stages: premultiply multiplier and pipelined restoring divider for unpremultiply
`timescale 1ns / 1ps
`default_nettype none

module pfc_alpha (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pfc_pkg::pfc_sw_type sw,
   output logic                     out_valid,
   output pfc_pkg::pfc_rsp_type     out_data
);
   import pfc_pkg::*;

   typedef struct packed {
      logic             valid;
      logic             last;
      pfc_mode_type     mode;
      logic [7:0]       alpha;
      logic [2:0][7:0]  chan;
      logic [2:0][15:0] prod;
      logic [2:0][7:0]  prem;
      logic [2:0]       sat;
      logic [2:0][15:0] num;
      logic [2:0][7:0]  rem;
      logic [2:0][7:0]  quo;
   } pfc_stage_type;

   pfc_stage_type stg_ff [DIV_STAGES+1];
   pfc_stage_type stg_in [DIV_STAGES+1];

   function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                           input logic [7:0] den);
      logic [8:0] trial;
      logic [8:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         return {1'b1, diff[7:0]};
      end
      return {1'b0, trial[7:0]};
   endfunction

   // first stage: products and dividend setup
   always_comb begin
      stg_in[0]       = '0;
      stg_in[0].valid = sw.valid;
      stg_in[0].last  = sw.last;
      stg_in[0].mode  = sw.mode;
      stg_in[0].alpha = sw.pix[3];
      for (int i = 0; i < 3; i++) begin
         stg_in[0].chan[i] = sw.pix[i];
         stg_in[0].prod[i] = {8'h00, sw.pix[i]} * {8'h00, sw.pix[3]};
         stg_in[0].num[i]  = {sw.pix[i], 8'h00} - {8'h00, sw.pix[i]};
         stg_in[0].rem[i]  = stg_in[0].num[i][15:8];
         stg_in[0].sat[i]  = sw.pix[i] >= sw.pix[3];
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      always_comb begin
         logic [8:0] hi;
         logic [8:0] lo;
         logic [15:0] rnd;
         stg_in[k] = stg_ff[k-1];
         for (int i = 0; i < 3; i++) begin
            hi = div_step(stg_ff[k-1].rem[i], stg_ff[k-1].num[i][9-2*k], stg_ff[k-1].alpha);
            lo = div_step(hi[7:0], stg_ff[k-1].num[i][8-2*k], stg_ff[k-1].alpha);
            stg_in[k].quo[i] = {stg_ff[k-1].quo[i][5:0], hi[8], lo[8]};
            stg_in[k].rem[i] = lo[7:0];
            rnd = stg_ff[k-1].prod[i] + {8'h00, stg_ff[k-1].prod[i][15:8]} + ROUND_HALF;
            if (k == 1) begin
               stg_in[k].prem[i] = rnd[15:8];
            end
         end
      end
   end

   for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[k].valid <= 1'b0;
         end else begin
            stg_ff[k].valid <= stg_in[k].valid;
         end
         stg_ff[k].last  <= stg_in[k].last;
         stg_ff[k].mode  <= stg_in[k].mode;
         stg_ff[k].alpha <= stg_in[k].alpha;
         stg_ff[k].chan  <= stg_in[k].chan;
         stg_ff[k].prod  <= stg_in[k].prod;
         stg_ff[k].prem  <= stg_in[k].prem;
         stg_ff[k].sat   <= stg_in[k].sat;
         stg_ff[k].num   <= stg_in[k].num;
         stg_ff[k].rem   <= stg_in[k].rem;
         stg_ff[k].quo   <= stg_in[k].quo;
      end
   end

   logic [2:0][7:0] res;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unique case (stg_ff[DIV_STAGES].mode)
            MODE_PREMUL:   res[i] = stg_ff[DIV_STAGES].prem[i];
            MODE_UNPREMUL: res[i] = stg_ff[DIV_STAGES].sat[i] ? 8'hFF
                                                              : stg_ff[DIV_STAGES].quo[i];
            default:       res[i] = stg_ff[DIV_STAGES].chan[i];
         endcase
      end
   end

   assign out_valid          = stg_ff[DIV_STAGES].valid;
   assign out_data.out_byte0 = res[0];
   assign out_data.out_byte1 = res[1];
   assign out_data.out_byte2 = res[2];
   assign out_data.out_byte3 = stg_ff[DIV_STAGES].alpha;
   assign out_data.out_last  = stg_ff[DIV_STAGES].last;

   pfc_div_rem_a: assert property (@(posedge clock) disable iff (reset)
      (stg_ff[DIV_STAGES].valid && stg_ff[DIV_STAGES].mode == MODE_UNPREMUL
       && !stg_ff[DIV_STAGES].sat[0])
      |-> (stg_ff[DIV_STAGES].rem[0] < stg_ff[DIV_STAGES].alpha))
      else $error("divider remainder not below alpha");

   pfc_premul_bound_a: assert property (@(posedge clock) disable iff (reset)
      (stg_ff[DIV_STAGES].valid && stg_ff[DIV_STAGES].mode == MODE_PREMUL)
      |-> (stg_ff[DIV_STAGES].prem[1] <= stg_ff[DIV_STAGES].chan[1]))
      else $error("premultiplied channel grew");

endmodule

`default_nettype wire

[hdl/pixel_format_converter.sv]
// pixel format converter top level: config registers, pipeline and output register
//
// one pixel per request on req_data, taken at a clock edge where start is high
// and busy is low; busy is high only during and just after reset, so a new
// request can be taken every clock
// csr_we/csr_index/csr_wdata write the layout and premultiply registers;
// write them only while no request is in flight
// results come out on rsp_data with the rsp_valid strobe for exactly one
// cycle, in request order; from the accepting edge on, the strobe passes the
// swizzle stage, product stage, four divider stages of two quotient bits each
// and the output register
// throughput is one pixel per clock, set by the fully pipelined divider
// reset clears all valid bits, sets busy and zeroes the config registers (BGRA
// source, BGRA-like destination, no premultiply); requests in flight are dropped
// the receiver cannot stall, so every result must be taken when strobed
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_converter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire pfc_pkg::pfc_req_type                 req_data,
   output logic                                      rsp_valid,
   output pfc_pkg::pfc_rsp_type                      rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [pfc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [pfc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import pfc_pkg::*;

   pfc_cfg_type cfg_ff;
   pfc_cfg_type cfg_in;
   logic        busy_ff;
   logic        accept;
   pfc_sw_type  sw;
   logic        alpha_valid;
   pfc_rsp_type alpha_data;
   logic        rsp_valid_ff;
   pfc_rsp_type rsp_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_LAYOUT: cfg_in.src_layout        = csr_wdata;
            CSR_DST_LAYOUT: cfg_in.dst_layout        = csr_wdata[1:0];
            CSR_SRC_PREMUL: cfg_in.src_premultiplied = csr_wdata[0];
            CSR_DST_PREMUL: cfg_in.dst_premultiplied = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= alpha_valid;
      end
      rsp_data_ff <= alpha_data;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   pfc_swizzle u_swizzle (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .sw     (sw)
   );

   pfc_alpha u_alpha (
      .clock     (clock),
      .reset     (reset),
      .sw        (sw),
      .out_valid (alpha_valid),
      .out_data  (alpha_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pfc_latency_a: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 rsp_valid)
      else $error("request produced no result");

   pfc_last_a: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 (rsp_data.out_last == $past(req_data.last_pixel, 7)))
      else $error("last marker out of order");

endmodule

`default_nettype wire

[bench/pfc_checker.sv]
// pixel format converter checker: predicts each converted pixel and compares the results
`timescale 1ns / 1ps

module pfc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  pfc_pkg::pfc_req_type            req_data,
   input  logic                            rsp_valid,
   input  pfc_pkg::pfc_rsp_type            rsp_data,
   input  logic                            csr_we,
   input  logic [pfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pfc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              pending,
   output int                              errors
);
   import pfc_pkg::*;

   typedef enum logic [1:0] {
      ORDER_KEEP,
      ORDER_REVERSE,
      ORDER_SWAP_RB,
      ORDER_ROTATE
   } byte_order_type;

   pfc_cfg_type cfg = '0;
   pfc_rsp_type expected_pixels [$];
   int mismatch_count = 0;
   int queued = 0;

   assign pending = queued;
   assign errors  = mismatch_count;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   function automatic pfc_rsp_type convert_pixel(input pfc_req_type px, input pfc_cfg_type c);
      logic [7:0] s [4];
      logic [7:0] d [4];
      byte_order_type order;
      logic packed_src;
      logic flip;
      pfc_mode_type mode;
      logic [7:0] alpha;
      int prod;
      int quot;
      pfc_rsp_type r;
      s[0] = px.in_byte0;
      s[1] = px.in_byte1;
      s[2] = px.in_byte2;
      s[3] = px.in_byte3;
      packed_src = (c.src_layout == LAYOUT_BGR) || (c.src_layout == LAYOUT_RGB);
      order = ORDER_KEEP;
      flip = 1'b0;
      if (c.dst_layout == DST_BGRA_LIKE) begin
         unique case (c.src_layout)
            LAYOUT_ARGB: order = ORDER_REVERSE;
            LAYOUT_RGBA: order = ORDER_SWAP_RB;
            LAYOUT_ABGR: order = ORDER_ROTATE;
            LAYOUT_RGB:  flip = 1'b1;
            default: ;
         endcase
      end else if (c.dst_layout == DST_RGBA_LIKE) begin
         unique case (c.src_layout)
            LAYOUT_ABGR: order = ORDER_REVERSE;
            LAYOUT_BGRA: order = ORDER_SWAP_RB;
            LAYOUT_ARGB: order = ORDER_ROTATE;
            LAYOUT_BGR:  flip = 1'b1;
            default: ;
         endcase
      end

      if (packed_src) begin
         d[0] = flip ? s[2] : s[0];
         d[1] = s[1];
         d[2] = flip ? s[0] : s[2];
         d[3] = ALPHA_OPAQUE;
         mode = MODE_COPY;
      end else begin
         unique case (order)
            ORDER_REVERSE: d = '{s[3], s[2], s[1], s[0]};
            ORDER_SWAP_RB: d = '{s[2], s[1], s[0], s[3]};
            ORDER_ROTATE:  d = '{s[1], s[2], s[3], s[0]};
            default:       d = '{s[0], s[1], s[2], s[3]};
         endcase
         if (c.src_premultiplied == c.dst_premultiplied) begin
            mode = MODE_COPY;
         end else begin
            mode = c.src_premultiplied ? MODE_UNPREMUL : MODE_PREMUL;
         end
      end

      alpha = d[3];
      if (mode != MODE_COPY) begin
         if (alpha == ALPHA_CLEAR) begin
            d = '{ALPHA_CLEAR, ALPHA_CLEAR, ALPHA_CLEAR, ALPHA_CLEAR};
         end else if (alpha != ALPHA_OPAQUE) begin
            for (int i = 0; i < 3; i++) begin
               if (mode == MODE_PREMUL) begin
                  prod = int'(d[i]) * int'(alpha);
                  d[i] = 8'((prod + (prod >> 8) + int'(ROUND_HALF)) >> 8);
               end else begin
                  quot = (int'(ALPHA_OPAQUE) * int'(d[i])) / int'(alpha);
                  d[i] = (quot > int'(ALPHA_OPAQUE)) ? ALPHA_OPAQUE : 8'(quot);
               end
            end
         end
      end

      r.out_byte0 = d[0];
      r.out_byte1 = d[1];
      r.out_byte2 = d[2];
      r.out_byte3 = d[3];
      r.out_last  = px.last_pixel;
      return r;
   endfunction

   always @(posedge clock) begin
      pfc_rsp_type want;
      if (reset) begin
         expected_pixels.delete();
         cfg = '0;
         queued <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result %h with no request pending", rsp_data));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.out_byte0 !== want.out_byte0)
                  report_mismatch($sformatf("out_byte0 got %h want %h",
                                            rsp_data.out_byte0, want.out_byte0));
               if (rsp_data.out_byte1 !== want.out_byte1)
                  report_mismatch($sformatf("out_byte1 got %h want %h",
                                            rsp_data.out_byte1, want.out_byte1));
               if (rsp_data.out_byte2 !== want.out_byte2)
                  report_mismatch($sformatf("out_byte2 got %h want %h",
                                            rsp_data.out_byte2, want.out_byte2));
               if (rsp_data.out_byte3 !== want.out_byte3)
                  report_mismatch($sformatf("out_byte3 got %h want %h",
                                            rsp_data.out_byte3, want.out_byte3));
               if (rsp_data.out_last !== want.out_last)
                  report_mismatch($sformatf("out_last got %b want %b",
                                            rsp_data.out_last, want.out_last));
            end
         end
         if (start && !busy) begin
            expected_pixels.push_back(convert_pixel(req_data, cfg));
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_SRC_LAYOUT: cfg.src_layout = csr_wdata[2:0];
               CSR_DST_LAYOUT: cfg.dst_layout = csr_wdata[1:0];
               CSR_SRC_PREMUL: cfg.src_premultiplied = csr_wdata[0];
               CSR_DST_PREMUL: cfg.dst_premultiplied = csr_wdata[0];
               default: ;
            endcase
         end
         queued <= expected_pixels.size();
      end
   end

endmodule

[bench/tb_top.sv]
// testbench top for the pixel format converter: clock, reset, requests, settings and verdict
`timescale 1ns / 1ps

module tb_top;
   import pfc_pkg::*;

   localparam logic [2:0] LAYOUT_UNDEFINED = 3'd7;
   localparam logic [1:0] DST_PLAIN_COPY   = 2'd2;
   localparam logic [1:0] DST_UNUSED       = 2'd3;
   localparam int IDLE_MAX    = 3;
   localparam int ITEM_TARGET = 1250;
   localparam int DRAIN_WAIT  = 20;
   localparam int CYCLE_LIMIT = 200000;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   pfc_req_type            req_data = '0;
   logic                   rsp_valid;
   pfc_rsp_type            rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     pending;
   int                     errors;
   int                     cycles = 0;

   pixel_format_converter dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pfc_checker pixel_check (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pending   (pending),
      .errors    (errors)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [7:0] random_byte();
      int pick;
      pick = $urandom_range(0, 15);
      unique case (pick)
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h01;
         3: return 8'hFE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input pfc_req_type px, input int max_gap);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_requests();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   // unused high bits of the write data are randomized
   task automatic apply_config(input pfc_cfg_type c);
      drain_requests();
      csr_we <= 1'b1;
      csr_index <= CSR_SRC_LAYOUT;
      csr_wdata <= c.src_layout;
      @(posedge clock);
      csr_index <= CSR_DST_LAYOUT;
      csr_wdata <= {1'($urandom), c.dst_layout};
      @(posedge clock);
      csr_index <= CSR_SRC_PREMUL;
      csr_wdata <= {2'($urandom), c.src_premultiplied};
      @(posedge clock);
      csr_index <= CSR_DST_PREMUL;
      csr_wdata <= {2'($urandom), c.dst_premultiplied};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      pfc_cfg_type cfg;
      int sent;
      int phase;
      int count;
      int gap_max;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: plain copy
      send_pixel({8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, IDLE_MAX);
      send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}, IDLE_MAX);
      send_pixel({8'h12, 8'h34, 8'h56, 8'h78, 1'b0}, IDLE_MAX);

      // premultiply, alpha in the first source byte
      apply_config('{src_layout: LAYOUT_ARGB, dst_layout: DST_BGRA_LIKE,
                     src_premultiplied: 1'b0, dst_premultiplied: 1'b1});
      send_pixel({8'h00, 8'hFF, 8'h80, 8'h01, 1'b0}, IDLE_MAX);
      send_pixel({8'h01, 8'hFF, 8'h80, 8'h01, 1'b0}, IDLE_MAX);
      send_pixel({8'h80, 8'hFF, 8'h80, 8'h01, 1'b0}, IDLE_MAX);
      send_pixel({8'hFE, 8'hFF, 8'h80, 8'h01, 1'b0}, IDLE_MAX);
      send_pixel({8'hFF, 8'hFF, 8'h80, 8'h01, 1'b1}, IDLE_MAX);

      // unpremultiply, including saturation when a color exceeds alpha
      apply_config('{src_layout: LAYOUT_RGBA, dst_layout: DST_RGBA_LIKE,
                     src_premultiplied: 1'b1, dst_premultiplied: 1'b0});
      send_pixel({8'hFF, 8'h80, 8'h01, 8'h01, 1'b0}, IDLE_MAX);
      send_pixel({8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0}, IDLE_MAX);
      send_pixel({8'h40, 8'h40, 8'h40, 8'h40, 1'b0}, IDLE_MAX);
      send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, IDLE_MAX);
      send_pixel({8'h10, 8'h20, 8'h30, 8'hFE, 1'b1}, IDLE_MAX);

      // packed source with opposite order: alpha forced opaque, no premultiply
      apply_config('{src_layout: LAYOUT_BGR, dst_layout: DST_RGBA_LIKE,
                     src_premultiplied: 1'b0, dst_premultiplied: 1'b1});
      send_pixel({8'h01, 8'h02, 8'h03, 8'h00, 1'b1}, IDLE_MAX);
      send_pixel({8'hFF, 8'h00, 8'hFF, 8'h55, 1'b0}, IDLE_MAX);

      // plain-copy destination still goes through premultiply
      apply_config('{src_layout: LAYOUT_ABGR, dst_layout: DST_PLAIN_COPY,
                     src_premultiplied: 1'b0, dst_premultiplied: 1'b1});
      send_pixel({8'h80, 8'hC0, 8'h40, 8'h7F, 1'b0}, IDLE_MAX);

      // undefined source layout and unused destination class
      apply_config('{src_layout: LAYOUT_UNDEFINED, dst_layout: DST_UNUSED,
                     src_premultiplied: 1'b1, dst_premultiplied: 1'b0});
      send_pixel({8'h80, 8'h40, 8'h20, 8'h10, 1'b0}, IDLE_MAX);
      send_pixel({8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1}, IDLE_MAX);

      sent = 0;
      phase = 0;
      while (sent < ITEM_TARGET) begin
         if (phase == 0) begin
            cfg = '0;
         end else if (phase == 1) begin
            cfg = '{src_layout: LAYOUT_UNDEFINED, dst_layout: DST_UNUSED,
                    src_premultiplied: 1'b1, dst_premultiplied: 1'b1};
         end else begin
            cfg.src_layout = 3'($urandom_range(0, 7));
            cfg.dst_layout = 2'($urandom_range(0, 3));
            cfg.src_premultiplied = 1'($urandom_range(0, 1));
            cfg.dst_premultiplied = ($urandom_range(0, 3) == 0) ? cfg.src_premultiplied
                                                               : ~cfg.src_premultiplied;
         end
         apply_config(cfg);
         count = $urandom_range(1, 60);
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
         repeat (count) begin
            send_pixel({random_byte(), random_byte(), random_byte(), random_byte(),
                        1'($urandom_range(0, 7) == 0)}, gap_max);
         end
         sent += count;
         phase++;
      end

      drain_requests();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/pfc_pkg.sv
hdl/pfc_swizzle.sv
hdl/pfc_alpha.sv
hdl/pixel_format_converter.sv
bench/pfc_checker.sv
bench/tb_top.sv
